// ===== hw/rtl/cltgn_pkg.sv =====
// ----------------------------------------------------------------------------
// CLT Gaussian noise generator package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package cltgn_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int TAG_W       = 8;
	localparam int SAMPLE_W    = 32;
	localparam int MEAN_W      = 32;
	localparam int SIGMA_W     = 24;
	localparam int SIGMA_HALF_W = 12;
	localparam int SEED_REG_W  = 20;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_MEAN  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIGMA = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SEED  = 2'd2;

	localparam logic [MEAN_W-1:0]     MEAN_RESET  = 32'd0;
	localparam logic [SIGMA_W-1:0]    SIGMA_RESET = 24'd65536;
	localparam logic [SEED_REG_W-1:0] SEED_RESET  = 20'd13579;

	localparam logic [11:0] LCG_MULT = 12'd2045;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7fff_ffff;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;    // capture tag, preload the sum with minus the offset
		logic step;     // advance the seed once and accumulate it
		logic mul_lo;   // x times low half of sigma
		logic mul_hi;   // x times high half of sigma
		logic combine;  // join partial products
		logic finish;   // shift, add mean, saturate, load output word
	} cmd_t;

endpackage

// ===== hw/rtl/cltgn_ctrl.sv =====
// ----------------------------------------------------------------------------
// CLT Gaussian noise generator controller
// Sequences the seed steps and the scale stages, and owns both handshakes.
// ----------------------------------------------------------------------------
module cltgn_ctrl #(
	parameter int NUM_UNIFORMS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output cltgn_pkg::cmd_t  cmd
);
	import cltgn_pkg::*;

	localparam int CNT_W = $clog2(NUM_UNIFORMS);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_RUN     = 3'd1;
	localparam logic [2:0] ST_MUL_LO  = 3'd2;
	localparam logic [2:0] ST_MUL_HI  = 3'd3;
	localparam logic [2:0] ST_COMBINE = 3'd4;
	localparam logic [2:0] ST_FINISH  = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             last_step;
	logic             out_free;

	assign last_step = (cnt_q == CNT_W'(NUM_UNIFORMS - 1));
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (last_step) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_COMBINE;
			end
			ST_COMBINE: begin
				cmd.combine = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				// Hold here while the previous word still sits unread.
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/cltgn_datapath.sv =====
// ----------------------------------------------------------------------------
// CLT Gaussian noise generator datapath
// Seed generator, uniform accumulator, split sigma multiply and saturation.
// ----------------------------------------------------------------------------
module cltgn_datapath #(
	parameter int NUM_UNIFORMS = 12,
	parameter int SEED_BITS    = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cltgn_pkg::cmd_t                       cmd,
	input  logic                                  cfg_we,
	input  logic [cltgn_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cltgn_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [cltgn_pkg::TAG_W-1:0]           request_tag,
	output logic signed [cltgn_pkg::SAMPLE_W-1:0] sample,
	output logic [cltgn_pkg::TAG_W-1:0]           tag_back,
	output logic                                  clipped
);
	import cltgn_pkg::*;

	localparam int SUM_W  = SEED_BITS + $clog2(NUM_UNIFORMS);
	localparam int X_W    = SUM_W + 1;
	localparam int PP_W   = X_W + SIGMA_HALF_W + 1;
	localparam int PROD_W = X_W + SIGMA_W + 1;
	localparam int SH_W   = PROD_W - SEED_BITS;
	localparam int TOT_W  = ((SH_W > SAMPLE_W) ? SH_W : SAMPLE_W) + 1;
	localparam logic [X_W-1:0] HALF = X_W'(NUM_UNIFORMS) << (SEED_BITS - 1);

	logic [MEAN_W-1:0]         mean_q;
	logic [SIGMA_W-1:0]        sigma_q;
	logic [SEED_BITS-1:0]      seed_q;
	logic [SEED_BITS-1:0]      seed_next;
	logic [TAG_W-1:0]          tag_q;
	logic signed [X_W-1:0]     sum_q;
	logic signed [PP_W-1:0]    plo_q, phi_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [SH_W-1:0]    shifted;
	logic signed [TOT_W-1:0]   total;
	logic [TOT_W-SAMPLE_W:0]   total_top;
	logic                      over;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [TAG_W-1:0]          tag_back_q;
	logic                      clipped_q;

	assign seed_next = seed_q * SEED_BITS'(LCG_MULT) + SEED_BITS'(1);

	// Partial products are joined with the high half weighted by 2^12.
	assign prod_d = (PROD_W'(phi_q) <<< SIGMA_HALF_W) + PROD_W'(plo_q);

	// Arithmetic shift of the exact product is a floor division.
	assign shifted   = SH_W'(prod_q >>> SEED_BITS);
	assign total     = TOT_W'($signed(mean_q)) + TOT_W'(shifted);
	assign total_top = total[TOT_W-1:SAMPLE_W-1];
	assign over      = !((&total_top) || !(|total_top));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= MEAN_RESET;
			sigma_q <= SIGMA_RESET;
			seed_q  <= SEED_BITS'(SEED_RESET);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MEAN:  mean_q  <= cfg_data[MEAN_W-1:0];
					REG_SIGMA: sigma_q <= cfg_data[SIGMA_W-1:0];
					REG_SEED:  seed_q  <= SEED_BITS'(cfg_data[SEED_REG_W-1:0]);
					default: begin
					end
				endcase
			end else if (cmd.step) begin
				seed_q <= seed_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			tag_q <= request_tag;
			// Starting from minus the offset leaves the centered value at the end.
			sum_q <= -$signed(HALF);
		end else if (cmd.step) begin
			sum_q <= sum_q + $signed(X_W'(seed_next));
		end
		if (cmd.mul_lo) begin
			plo_q <= PP_W'(sum_q * $signed({1'b0, sigma_q[SIGMA_HALF_W-1:0]}));
		end
		if (cmd.mul_hi) begin
			phi_q <= PP_W'(sum_q * $signed({1'b0, sigma_q[SIGMA_W-1:SIGMA_HALF_W]}));
		end
		if (cmd.combine) begin
			prod_q <= prod_d;
		end
		if (cmd.finish) begin
			tag_back_q <= tag_q;
			clipped_q  <= over;
			if (over) begin
				sample_q <= total[TOT_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
			end else begin
				sample_q <= total[SAMPLE_W-1:0];
			end
		end
	end

	assign sample   = sample_q;
	assign tag_back = tag_back_q;
	assign clipped  = clipped_q;

endmodule

// ===== hw/rtl/clt_gaussian_noise_generator_top.sv =====
// ----------------------------------------------------------------------------
// CLT Gaussian noise generator
// Approximately normal samples from a sum of linear congruential uniforms.
// ----------------------------------------------------------------------------
// Each accepted word yields one Q16.16 sample equal to mean plus the centered
// sum of NUM_UNIFORMS seed values times sigma, saturated to 32 bits with the
// clipped flag set on saturation. After acceptance the seed recurrence
// advances once per cycle while the sum takes in each seed value, then the
// sigma multiply runs as a low half and a high half, the partial products
// are joined and the last stage adds the mean, saturates and loads the
// output register. The controller then returns to idle; no new request is
// taken while one is in progress, and the last stage waits as long as the
// previous result is still stalled. The next request is taken as soon as
// the previous one has left the datapath, even while its result still
// waits downstream. Writing register 2 reloads the seed; configuration
// must only be written while the block is idle.
module clt_gaussian_noise_generator_top #(
	parameter int NUM_UNIFORMS = 12,
	parameter int SEED_BITS    = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [cltgn_pkg::TAG_W-1:0]           request_tag,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [cltgn_pkg::SAMPLE_W-1:0] sample,
	output logic [cltgn_pkg::TAG_W-1:0]           tag_back,
	output logic                                  clipped,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cltgn_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cltgn_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import cltgn_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	cltgn_ctrl #(
		.NUM_UNIFORMS(NUM_UNIFORMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	cltgn_datapath #(
		.NUM_UNIFORMS(NUM_UNIFORMS),
		.SEED_BITS   (SEED_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.request_tag (request_tag),
		.sample      (sample),
		.tag_back    (tag_back),
		.clipped     (clipped)
	);

`ifndef SYNTH
	// A new word keeps the input side busy while it is being worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	// A clipped word always carries one of the two saturation limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |-> (sample == SAMPLE_MAX || sample == SAMPLE_MIN))
		else $error("clipped sample is not at a limit");

	// The controller issues at most one datapath command per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.step, cmd.mul_lo, cmd.mul_hi, cmd.combine, cmd.finish}))
		else $error("overlapping datapath commands");
`endif

endmodule
